/* rtl/modexp_pkg.sv */
package modexp_pkg;

    // Datapath commands issued by the controller
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_MUL_SQ,
        CMD_MUL_BASE,
        CMD_RED_BASE
    } modexp_cmd_t;

    // Datapath status back to the controller
    typedef struct packed {
        logic busy;
        logic exp_bit;
        logic mod_zero;
    } modexp_status_t;

endpackage

/* rtl/modexp_ctrl.sv */
module modexp_ctrl #(
    parameter int WIDTH = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  logic                       out_ready,
    output modexp_pkg::modexp_cmd_t    cmd,
    input  modexp_pkg::modexp_status_t status
);
    import modexp_pkg::*;

    localparam int CW = $clog2(WIDTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_RED_BASE, S_SQ, S_MUL, S_WAIT_SQ, S_WAIT_MUL, S_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);

    // Sequence one reduction of the base (straight to done on a zero modulus), then square/multiply per exponent bit
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = CMD_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd        = CMD_LOAD;
                    cnt_next   = CW'(WIDTH);
                    state_next = S_RED_BASE;
                end
            end
            S_RED_BASE: begin
                if (status.mod_zero) begin
                    state_next = S_DONE;
                end else begin
                    cmd        = CMD_RED_BASE;
                    state_next = S_WAIT_SQ;
                end
            end
            S_SQ: begin
                cmd        = CMD_MUL_SQ;
                state_next = S_WAIT_MUL;
            end
            S_WAIT_MUL: begin
                if (!status.busy) begin
                    state_next = status.exp_bit ? S_MUL : S_WAIT_SQ;
                    if (!status.exp_bit) cnt_next = cnt_reg - 1'b1;
                end
            end
            S_MUL: begin
                cmd        = CMD_MUL_BASE;
                cnt_next   = cnt_reg - 1'b1;
                state_next = S_WAIT_SQ;
            end
            S_WAIT_SQ: begin
                if (!status.busy) begin
                    state_next = (cnt_reg == '0) ? S_DONE : S_SQ;
                end
            end
            S_DONE: begin
                if (out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state and bit counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* rtl/modexp_dp.sv */
module modexp_dp #(
    parameter int WIDTH = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  modexp_pkg::modexp_cmd_t    cmd,
    output modexp_pkg::modexp_status_t status,
    input  logic [WIDTH-1:0]           base_in,
    input  logic [WIDTH-1:0]           power_in,
    input  logic [WIDTH-1:0]           modulus,
    output logic [WIDTH-1:0]           result
);
    import modexp_pkg::*;

    localparam int PW = 2 * WIDTH;
    localparam int SW = $clog2(PW + 1);

    logic [WIDTH-1:0] base_reg, exp_reg, acc_reg;
    logic [PW-1:0]    rem_reg, rem_next;
    logic [PW-1:0]    prod_reg;
    logic [SW-1:0]    step_reg;
    logic             busy_reg, mul_pend_reg, to_base_reg;
    logic             exp_bit_reg;
    logic [WIDTH-1:0] mul_b;
    logic [PW-1:0]    rem_sh;
    logic             prod_bit;

    assign status.busy     = busy_reg | mul_pend_reg;
    assign status.exp_bit  = exp_bit_reg;
    assign status.mod_zero = (modulus == '0);
    assign result          = status.mod_zero ? '0 : acc_reg;

    // Restoring remainder step: shift in one product bit, subtract if it fits
    assign prod_bit = prod_reg[PW-1];
    assign rem_sh   = {rem_reg[PW-2:0], prod_bit};
    always_comb begin
        rem_next = rem_sh;
        if (rem_sh >= PW'(modulus)) rem_next = rem_sh - PW'(modulus);
    end

    assign mul_b = (cmd == CMD_MUL_BASE) ? base_reg : acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            mul_pend_reg <= 1'b0;
            to_base_reg  <= 1'b0;
        end else begin
            unique case (cmd)
                CMD_LOAD: begin
                    base_reg <= base_in;
                    // Latch operands and start from 1 mod m
                    exp_reg  <= power_in;
                    acc_reg  <= (modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
                end
                CMD_RED_BASE: begin
                    prod_reg    <= PW'(base_reg);
                    mul_pend_reg <= 1'b1;
                    to_base_reg <= 1'b1;
                end
                CMD_MUL_SQ, CMD_MUL_BASE: begin
                    prod_reg     <= PW'(acc_reg) * PW'(mul_b);
                    mul_pend_reg <= 1'b1;
                    to_base_reg  <= 1'b0;
                    // Take the next exponent bit as its square starts
                    if (cmd == CMD_MUL_SQ) begin
                        exp_bit_reg <= exp_reg[WIDTH-1];
                        exp_reg     <= {exp_reg[WIDTH-2:0], 1'b0};
                    end
                end
                CMD_NONE: begin
                    if (mul_pend_reg) begin
                        mul_pend_reg <= 1'b0;
                        busy_reg     <= 1'b1;
                        rem_reg      <= '0;
                        step_reg     <= SW'(PW);
                    end else if (busy_reg) begin
                        rem_reg  <= rem_next;
                        prod_reg <= {prod_reg[PW-2:0], 1'b0};
                        step_reg <= step_reg - 1'b1;
                        if (step_reg == SW'(1)) begin
                            busy_reg <= 1'b0;
                            if (to_base_reg) base_reg <= rem_next[WIDTH-1:0];
                            else             acc_reg  <= rem_next[WIDTH-1:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

/* rtl/modular_exponentiation.sv */
// Each product and the base reduction go through the bit-serial remainder unit (2*WIDTH steps per reduction).
// Throughput: one item at a time; the next beat is taken after the result leaves.
// Reset (aresetn low, synchronous): controller idle, modulus returns to 1.
module modular_exponentiation #(
    parameter int WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] base, [63:32] power
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] residue
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);
    import modexp_pkg::*;

    logic [31:0]    modulus_reg;
    modexp_cmd_t    cmd;
    modexp_status_t status;
    logic [WIDTH-1:0] res;

    // Hold the modulus register
    always_ff @(posedge aclk) begin
        if (!aresetn) modulus_reg <= 32'd1;
        else if (cfg_we) modulus_reg <= cfg_wdata;
    end

    modexp_ctrl #(.WIDTH(WIDTH)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .cmd(cmd), .status(status)
    );

    modexp_dp #(.WIDTH(WIDTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .status(status),
        .base_in(s_tdata[WIDTH-1:0]),
        .power_in(s_tdata[32+WIDTH-1:32]),
        .modulus(modulus_reg[WIDTH-1:0]),
        .result(res)
    );

    assign m_tdata = 32'(res);

endmodule
